FILE: sv/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH     = 64;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int IN_DATA_W  = ((ID_BITS + PRIO_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_BITS + PRIO_BITS + 2 + CNT_W + 7) / 8) * 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the captured request to the cells
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

FILE: sv/spq_ctrl.sv
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_tready,
  input  spq_pkg::status_t status_i,
  output spq_pkg::cmd_t    cmd_o
);
  import spq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   slot_free;

  // result slot is free now or drains at this edge
  assign slot_free = !status_i.out_valid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && slot_free) state_nxt = ST_RUN;
      end
      ST_RUN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = slot_free;
        cmd_o.load = in_tvalid && slot_free;
      end
      ST_RUN: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> (state_r == ST_RUN))
    else $error("load not followed by run");
  a_run_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.exec |-> !status_i.out_valid)
    else $error("run with result slot still occupied");
`endif

endmodule

FILE: sv/spq_dp.sv
module spq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::cmd_t                       cmd_i,
  output spq_pkg::status_t                    status_o,
  input  logic                                in_op,
  input  logic [spq_pkg::ID_BITS-1:0]         in_id,
  input  logic [spq_pkg::PRIO_BITS-1:0]       in_prio,
  input  logic                                out_tready,
  output logic [spq_pkg::ID_BITS-1:0]         res_id,
  output logic [spq_pkg::PRIO_BITS-1:0]       res_prio,
  output logic                                res_empty,
  output logic                                res_full,
  output logic [spq_pkg::CNT_W-1:0]           res_count
);
  import spq_pkg::*;

  // captured request
  op_t                  op_r;
  logic [ID_BITS-1:0]   req_id_r;
  logic [PRIO_BITS-1:0] req_prio_r;

  // sorted cell row, head at index 0
  logic [ID_BITS-1:0]   cell_id_r   [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio_r [DEPTH];
  logic [ID_BITS-1:0]   cell_id_nxt   [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio_nxt [DEPTH];
  logic [DEPTH-1:0]     moves;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  logic                 out_valid_r;
  logic [ID_BITS-1:0]   res_id_r;
  logic [PRIO_BITS-1:0] res_prio_r;
  logic                 res_empty_r;
  logic                 res_full_r;
  logic [CNT_W-1:0]     res_count_r;

  logic is_full;
  logic is_empty;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r       <= op_t'(in_op);
      req_id_r   <= in_id;
      req_prio_r <= in_prio;
    end
  end

  // a valid cell with a larger priority steps back on insert
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      moves[k] = (CNT_W'(k) < count_r) && (cell_prio_r[k] > req_prio_r);
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int k = 0; k < DEPTH; k++) begin
      cell_id_nxt[k]   = cell_id_r[k];
      cell_prio_nxt[k] = cell_prio_r[k];
    end
    case (op_r)
      OP_INSERT: begin
        if (!is_full) begin
          count_nxt = count_r + CNT_W'(1);
          for (int k = 0; k < DEPTH; k++) begin
            if (k > 0 && moves[(k > 0) ? k - 1 : 0]) begin
              cell_id_nxt[k]   = cell_id_r[(k > 0) ? k - 1 : 0];
              cell_prio_nxt[k] = cell_prio_r[(k > 0) ? k - 1 : 0];
            end else if (moves[k] || (CNT_W'(k) == count_r)) begin
              cell_id_nxt[k]   = req_id_r;
              cell_prio_nxt[k] = req_prio_r;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (!is_empty) begin
          count_nxt = count_r - CNT_W'(1);
          for (int k = 0; k < DEPTH - 1; k++) begin
            cell_id_nxt[k]   = cell_id_r[k + 1];
            cell_prio_nxt[k] = cell_prio_r[k + 1];
          end
        end
      end
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        cell_id_r[k]   <= cell_id_nxt[k];
        cell_prio_r[k] <= cell_prio_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      res_count_r <= count_nxt;
      if (op_r == OP_REMOVE && !is_empty) begin
        res_id_r   <= cell_id_r[0];
        res_prio_r <= cell_prio_r[0];
      end else begin
        res_id_r   <= '0;
        res_prio_r <= '0;
      end
      res_empty_r <= (op_r == OP_REMOVE) && is_empty;
      res_full_r  <= (op_r == OP_INSERT) && is_full;
    end
  end

  assign status_o.out_valid = out_valid_r;
  assign res_id    = res_id_r;
  assign res_prio  = res_prio_r;
  assign res_empty = res_empty_r;
  assign res_full  = res_full_r;
  assign res_count = res_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.exec |=> (out_valid_r && res_count_r == count_r))
    else $error("result count disagrees with stored count");
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_prio_r[0] <= cell_prio_r[1]))
    else $error("head entries out of order");
`endif

endmodule

FILE: sv/stable_priority_queue.sv
// Stable priority queue, sorted cell row of DEPTH (id, priority) entries.
// Input channel in_*: in_tuser is the operation (0 insert, 1 remove head);
// in_tdata carries the id and priority of an insert. A transfer happens when
// in_tvalid and in_tready are both high.
// Result channel out_*: exactly one result transfer per request, in order:
// the removed head id and priority (zero for an insert or an empty remove),
// the empty and full flags and the entry count after the operation.
// Equal priorities leave in arrival order; an insert into a full queue is
// dropped and flagged, the stored entries left as they were.
// The request is captured when it transfers; out_tvalid rises at the clock
// edge after that, together with the update of the cells.
// The block takes no new request while it applies one; the controller
// captures it in one state and updates all cells in parallel in the next.
// The result sits in an output register; a stalled receiver holds it there
// and in_tready stays low until that result transfers (a request may
// transfer at the same edge as the waiting result).
// Reset (rst_n low, synchronous) empties the queue and clears out_tvalid;
// stored cell contents are not cleared, they are never read beyond the count.
module stable_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]      in_tdata,  // item_id[15:0], priority_req[23:16]
  input  logic                               in_tuser,  // op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]     out_tdata  // out_id[15:0], out_priority[23:16],
                                                        // was_empty[24], was_full[25],
                                                        // count[32:26], zero[39:33]
);
  import spq_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [ID_BITS-1:0]   res_id;
  logic [PRIO_BITS-1:0] res_prio;
  logic                 res_empty;
  logic                 res_full;
  logic [CNT_W-1:0]     res_count;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_op      (in_tuser),
    .in_id      (in_tdata[ID_BITS-1:0]),
    .in_prio    (in_tdata[ID_BITS +: PRIO_BITS]),
    .out_tready (out_tready),
    .res_id     (res_id),
    .res_prio   (res_prio),
    .res_empty  (res_empty),
    .res_full   (res_full),
    .res_count  (res_count)
  );

  assign out_tvalid = status.out_valid;
  // pack result fields from the lowest bit up, zero fill to whole bytes
  assign out_tdata  = {(OUT_DATA_W - ID_BITS - PRIO_BITS - 2 - CNT_W)'(0),
                       res_count, res_full, res_empty, res_prio, res_id};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 3;
  localparam int PHASE_ITEMS  = 475;     // random transfers per idling phase
  localparam int SETTLE_LIMIT = 16;      // quiet cycles after the last result
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest correct run
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    op_t                  op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } queue_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic                 empty;
    logic                 full;
    logic [CNT_W-1:0]     count;
  } queue_resp_t;

  // Idling mix per phase: none, slow sender, slow receiver, both moderate.
  localparam int NUM_PHASES = 4;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 88, 0, 35};
  localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 88, 35};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  stable_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Requests waiting to be driven, and results owed by the block, oldest first.
  queue_req_t  pending_reqs[$];
  queue_resp_t owed_results[$];

  // Shadow of the sorted entry row: ascending priority, arrival order on ties.
  logic [ID_BITS-1:0]   shadow_id  [DEPTH];
  logic [PRIO_BITS-1:0] shadow_prio[DEPTH];
  int                   shadow_count = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  logic in_taken      = 1'b0;  // request transfer seen at the last rising edge
  int  cycle_count    = 0;
  int  accepted_count = 0;
  int  checked_count  = 0;
  int  mismatch_count = 0;
  int  full_drops     = 0;
  int  empty_removes  = 0;
  int  peak_count     = 0;

  // Apply one request to the shadow row and return the result it must cause.
  function automatic queue_resp_t apply_to_shadow(queue_req_t req);
    queue_resp_t resp;
    int          pos;
    int          k;
    resp = '0;
    if (req.op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        // drop the entry, leave the row as it is
        resp.full = 1'b1;
        full_drops++;
      end else begin
        // skip every entry with lower or equal priority, keeping ties stable
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= req.prio) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_id[k]   = shadow_id[k - 1];
          shadow_prio[k] = shadow_prio[k - 1];
        end
        shadow_id[pos]   = req.id;
        shadow_prio[pos] = req.prio;
        shadow_count++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end else begin
      if (shadow_count == 0) begin
        resp.empty = 1'b1;
        empty_removes++;
      end else begin
        resp.id   = shadow_id[0];
        resp.prio = shadow_prio[0];
        for (k = 1; k < shadow_count; k++) begin
          shadow_id[k - 1]   = shadow_id[k];
          shadow_prio[k - 1] = shadow_prio[k];
        end
        shadow_count--;
      end
    end
    resp.count = shadow_count[CNT_W-1:0];
    return resp;
  endfunction

  task automatic add_request(op_t op, logic [ID_BITS-1:0] id, logic [PRIO_BITS-1:0] prio);
    queue_req_t req;
    req.op   = op;
    req.id   = id;
    req.prio = prio;
    pending_reqs.push_back(req);
  endtask

  // Mix extremes, coarse values that collide often, and the full range.
  function automatic logic [PRIO_BITS-1:0] random_priority();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_BITS'($urandom_range(7) << 5);
      default: return PRIO_BITS'($urandom_range((1 << PRIO_BITS) - 1));
    endcase
  endfunction

  // Queue a run of requests where insert_pct of them are inserts; removes carry
  // random payload, which the block must ignore.
  task automatic add_traffic_segment(int insert_pct, int len);
    int n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(99) < insert_pct)
        add_request(OP_INSERT, ID_BITS'($urandom), random_priority());
      else
        add_request(OP_REMOVE, ID_BITS'($urandom), PRIO_BITS'($urandom));
    end
  endtask

  task automatic report_mismatch(string what, queue_resp_t want, queue_resp_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0d] %s: expected id=%h prio=%h empty=%b full=%b count=%0d",
               cycle_count, what, want.id, want.prio, want.empty, want.full, want.count);
      $display("[%0d] %s: got      id=%h prio=%h empty=%b full=%b count=%0d",
               cycle_count, what, got.id, got.prio, got.empty, got.full, got.count);
    end
  endtask

  // Driver: advance to the next request once the current one transferred,
  // hold it otherwise; insert random gaps by the phase's sender idle rate.
  always @(negedge clk) begin : request_driver
    queue_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= req.op;
        in_tdata  <= {req.prio, req.id};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random by the phase's stall rate.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on every request transfer, then check every result
  // transfer against the oldest owed result.
  always @(posedge clk) begin : monitor
    queue_req_t  req;
    queue_resp_t got;
    queue_resp_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      cycle_count++;
      if (in_tvalid && in_tready) begin
        req.op   = op_t'(in_tuser);
        req.id   = in_tdata[ID_BITS-1:0];
        req.prio = in_tdata[ID_BITS +: PRIO_BITS];
        owed_results.push_back(apply_to_shadow(req));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        got.id    = out_tdata[ID_BITS-1:0];
        got.prio  = out_tdata[ID_BITS +: PRIO_BITS];
        got.empty = out_tdata[ID_BITS + PRIO_BITS];
        got.full  = out_tdata[ID_BITS + PRIO_BITS + 1];
        got.count = out_tdata[ID_BITS + PRIO_BITS + 2 +: CNT_W];
        checked_count++;
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got.id != want.id || got.prio != want.prio || got.empty != want.empty ||
              got.full != want.full || got.count != want.count)
            report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, owed_results.size());
    $display("** stable_priority_queue: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int left;
    int len;

    // Directed: empty remove, extremes, ties at both ends of the range,
    // drain in order, then remove from empty again.
    add_request(OP_REMOVE, 16'hBEEF, 8'hC3);
    add_request(OP_INSERT, 16'h0000, 8'h00);
    add_request(OP_INSERT, 16'hFFFF, 8'hFF);
    add_request(OP_INSERT, 16'h1234, 8'h00);
    add_request(OP_INSERT, 16'h5555, 8'hFF);
    add_request(OP_INSERT, 16'h00FF, 8'h80);
    add_request(OP_INSERT, 16'hFF00, 8'h7F);
    add_request(OP_INSERT, 16'hA5A5, 8'h80);
    repeat (7) add_request(OP_REMOVE, 16'hFFFF, 8'hFF);
    add_request(OP_REMOVE, 16'h0000, 8'h00);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      // Overfill so inserts hit a full row, wander with fill, drain and churn
      // runs, then empty the row and remove past the bottom.
      add_traffic_segment(100, DEPTH + 6);
      left = PHASE_ITEMS - 2 * (DEPTH + 6);
      while (left > 0) begin
        len = $urandom_range(16, 80);
        if (len > left) len = left;
        case ($urandom_range(2))
          0:       add_traffic_segment(85, len);
          1:       add_traffic_segment(15, len);
          default: add_traffic_segment(50, len);
        endcase
        left -= len;
      end
      add_traffic_segment(0, DEPTH + 6);
      // Wait until every request transferred and every owed result arrived;
      // sample at the rising edge, where the driven request has settled.
      do @(posedge clk);
      while (pending_reqs.size() != 0 || in_tvalid || owed_results.size() != 0);
    end

    // Let any stray result surface before closing.
    repeat (SETTLE_LIMIT) @(negedge clk);
    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
      mismatch_count += owed_results.size();
    end

    $display("Covered %0d requests over %0d idling phases, %0d results checked, %0d mismatches.",
             accepted_count, NUM_PHASES, checked_count, mismatch_count);
    $display("Saw %0d inserts dropped on a full row, %0d removes from empty, peak fill %0d.",
             full_drops, empty_removes, peak_count);
    if (mismatch_count == 0)
      $display("** stable_priority_queue: PASSED **");
    else
      $display("** stable_priority_queue: FAILED **");
    $finish;
  end

endmodule
